// File: rtl/lr_shift_reduce_parse_engine_unit_assert.svh
// Assertion macros used by the parse engine checker.
`ifndef LR_SHIFT_REDUCE_PARSE_ENGINE_UNIT_ASSERT_SVH
`define LR_SHIFT_REDUCE_PARSE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRSR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lrsr_pkg.sv
// Types and constants shared by the parse engine modules.
`default_nettype none

package lrsr_pkg;

    // input item modes
    localparam logic [2:0] MODE_TOKEN    = 3'd0;
    localparam logic [2:0] MODE_ACT_WR   = 3'd1;
    localparam logic [2:0] MODE_GOTO_WR  = 3'd2;
    localparam logic [2:0] MODE_RULE_WR  = 3'd3;
    localparam logic [2:0] MODE_RESTART  = 3'd4;

    // depth of the command queue and of the result queue
    localparam int QDEPTH = 4;

    typedef enum logic [2:0] {
        OP_TOKEN   = 3'd0,
        OP_ACT_WR  = 3'd1,
        OP_GOTO_WR = 3'd2,
        OP_RULE_WR = 3'd3,
        OP_RESTART = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        K_EMPTY  = 2'd0,
        K_SHIFT  = 2'd1,
        K_REDUCE = 2'd2,
        K_ACCEPT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EV_SHIFT  = 3'd0,
        EV_REDUCE = 3'd1,
        EV_ACCEPT = 3'd2,
        EV_SYNTAX = 3'd3,
        EV_STACK  = 3'd4,
        EV_HALTED = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        RUN_GO  = 2'd0,
        RUN_ACC = 2'd1,
        RUN_ERR = 2'd2
    } t_run;

    typedef struct packed {
        t_op        op;
        logic [4:0] token;
        logic [6:0] tstate;
        logic [4:0] tterm;
        logic [3:0] tnt;
        logic [1:0] kind;
        logic [6:0] target;
        logic [6:0] rnum;
        logic [3:0] rlen;
    } t_cmd;

    typedef struct packed {
        t_event     event_res;
        logic [6:0] rule;
        logic [6:0] new_state;
        logic [6:0] stack_depth;
        logic       last;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/lrsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lrsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [WIDTH-1:0]   i_wdata,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [WIDTH-1:0]   o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/lrsr_fifo.sv
// Small register FIFO used for the command and result queues.
`default_nettype none

module lrsr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [WIDTH-1:0]   i_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic      [WIDTH-1:0]   o_data,
    output logic                    o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == CNTW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (w_do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + CNTW'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lrsr_front.sv
// Front end: takes input items, classifies them and queues commands.
`default_nettype none

module lrsr_front #(
    parameter int STATES       = 128,
    parameter int TERMINALS    = 32,
    parameter int NONTERMINALS = 16,
    parameter int RULES        = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [2:0]        i_mode,
    input  wire logic [4:0]        i_token,
    input  wire logic [6:0]        i_table_state,
    input  wire logic [4:0]        i_table_terminal,
    input  wire logic [3:0]        i_table_nonterminal,
    input  wire logic [1:0]        i_entry_kind,
    input  wire logic [6:0]        i_entry_target,
    input  wire logic [6:0]        i_rule_number,
    input  wire logic [3:0]        i_rule_length,
    input  wire logic              i_hold,
    output logic                   o_cmd_valid,
    output lrsr_pkg::t_cmd         o_cmd,
    input  wire logic              i_cmd_pop
);

    lrsr_pkg::t_cmd                   w_cmd;
    logic                             w_keep;
    logic                             w_qfull;
    logic                             w_qempty;
    logic [$bits(lrsr_pkg::t_cmd)-1:0] w_qdata;

    always_comb begin
        w_cmd.op     = lrsr_pkg::OP_TOKEN;
        w_cmd.token  = i_token;
        w_cmd.tstate = i_table_state;
        w_cmd.tterm  = i_table_terminal;
        w_cmd.tnt    = i_table_nonterminal;
        w_cmd.kind   = i_entry_kind;
        w_cmd.target = i_entry_target;
        w_cmd.rnum   = i_rule_number;
        w_cmd.rlen   = i_rule_length;
        w_keep       = 1'b0;
        unique case (i_mode)
            lrsr_pkg::MODE_TOKEN: begin
                w_cmd.op = lrsr_pkg::OP_TOKEN;
                w_keep   = 1'b1;
            end
            lrsr_pkg::MODE_ACT_WR: begin
                w_cmd.op = lrsr_pkg::OP_ACT_WR;
                w_keep   = (32'(i_table_state) < 32'(STATES))
                        && (32'(i_table_terminal) < 32'(TERMINALS));
            end
            lrsr_pkg::MODE_GOTO_WR: begin
                w_cmd.op = lrsr_pkg::OP_GOTO_WR;
                w_keep   = (32'(i_table_state) < 32'(STATES))
                        && (32'(i_table_nonterminal) < 32'(NONTERMINALS));
            end
            lrsr_pkg::MODE_RULE_WR: begin
                w_cmd.op = lrsr_pkg::OP_RULE_WR;
                w_keep   = (32'(i_rule_number) < 32'(RULES));
            end
            lrsr_pkg::MODE_RESTART: begin
                w_cmd.op = lrsr_pkg::OP_RESTART;
                w_keep   = 1'b1;
            end
            default: begin
                // unused modes: taken and dropped
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_full = w_qfull || i_hold;

    lrsr_fifo #(
        .WIDTH ($bits(lrsr_pkg::t_cmd)),
        .DEPTH (lrsr_pkg::QDEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full && w_keep),
        .i_data  (w_cmd),
        .o_full  (w_qfull),
        .i_pop   (i_cmd_pop),
        .o_data  (w_qdata),
        .o_empty (w_qempty)
    );

    assign o_cmd_valid = !w_qempty;
    assign o_cmd       = lrsr_pkg::t_cmd'(w_qdata);

endmodule

`default_nettype wire

// File: rtl/lrsr_back.sv
// Back end: table stores, state stack and the parse sequencer.
`default_nettype none

module lrsr_back #(
    parameter int STATES       = 128,
    parameter int TERMINALS    = 32,
    parameter int NONTERMINALS = 16,
    parameter int RULES        = 128,
    parameter int STACK_DEPTH  = 64,
    parameter int MAX_REDUCE   = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    input  lrsr_pkg::t_cmd         i_cmd,
    output logic                   o_cmd_pop,
    output logic                   o_hold,
    output logic                   o_res_valid,
    output lrsr_pkg::t_res         o_res,
    input  wire logic              i_res_full
);

    localparam int ADEPTH  = STATES * TERMINALS;
    localparam int GDEPTH  = STATES * NONTERMINALS;
    localparam int AAW     = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
    localparam int GAW     = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int RAW     = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int SAW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW      = $clog2(STACK_DEPTH + 1);
    localparam int NW      = $clog2(MAX_REDUCE + 1);
    localparam int CLR_LEN = (ADEPTH > GDEPTH) ? ADEPTH : GDEPTH;
    localparam int CLW     = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

    typedef enum logic [5:0] {
        BS_CLEAR = 6'b000001,
        BS_IDLE  = 6'b000010,
        BS_ACT   = 6'b000100,
        BS_RULE  = 6'b001000,
        BS_STK   = 6'b010000,
        BS_GOTO  = 6'b100000
    } t_bstate;

    t_bstate            r_state, n_state;
    logic [CLW-1:0]     r_clr, n_clr;
    logic [CW-1:0]      r_count, n_count;
    logic [6:0]         r_top, n_top;
    lrsr_pkg::t_run     r_status, n_status;
    logic [NW-1:0]      r_nred, n_nred;
    logic [4:0]         r_token, n_token;
    logic               r_act_oor, n_act_oor;
    logic               r_goto_oor, n_goto_oor;
    logic [6:0]         r_rule, n_rule;
    logic [3:0]         r_lhs, n_lhs;
    logic [CW-1:0]      r_base, n_base;

    // RAM ports
    logic               w_act_we, w_act_re;
    logic [AAW-1:0]     w_act_waddr, w_act_raddr;
    logic [8:0]         w_act_wdata, w_act_rd;
    logic               w_goto_we, w_goto_re;
    logic [GAW-1:0]     w_goto_waddr, w_goto_raddr;
    logic [6:0]         w_goto_wdata, w_goto_rd;
    logic               w_rule_we, w_rule_re;
    logic [RAW-1:0]     w_rule_waddr, w_rule_raddr;
    logic [7:0]         w_rule_wdata, w_rule_rd;
    logic               w_stk_we, w_stk_re;
    logic [SAW-1:0]     w_stk_waddr, w_stk_raddr;
    logic [6:0]         w_stk_wdata, w_stk_rd;

    lrsr_pkg::t_kind    w_kind;
    logic [6:0]         w_tgt;
    logic [3:0]         w_len;
    logic [3:0]         w_lhs;
    logic [CW-1:0]      w_base;
    logic [6:0]         w_g;

    function automatic logic [AAW-1:0] f_act_addr(input logic [6:0] st, input logic [4:0] tm);
        return AAW'(32'(st) * 32'(TERMINALS) + 32'(tm));
    endfunction

    function automatic logic f_act_oor(input logic [6:0] st, input logic [4:0] tm);
        return !((32'(st) < 32'(STATES)) && (32'(tm) < 32'(TERMINALS)));
    endfunction

    function automatic logic [GAW-1:0] f_goto_addr(input logic [6:0] st, input logic [3:0] nt);
        return GAW'(32'(st) * 32'(NONTERMINALS) + 32'(nt));
    endfunction

    function automatic lrsr_pkg::t_res f_res(
        input lrsr_pkg::t_event ev,
        input logic [6:0]       rule,
        input logic [6:0]       st,
        input logic [CW-1:0]    cnt,
        input logic             last
    );
        lrsr_pkg::t_res res;
        res.event_res   = ev;
        res.rule        = rule;
        res.new_state   = st;
        res.stack_depth = 7'(cnt);
        res.last        = last;
        return res;
    endfunction

    assign w_kind = r_act_oor ? lrsr_pkg::K_EMPTY : lrsr_pkg::t_kind'(w_act_rd[8:7]);
    assign w_tgt  = w_act_rd[6:0];
    assign w_len  = w_rule_rd[3:0];
    assign w_lhs  = w_rule_rd[7:4];
    assign w_base = CW'(32'(r_count) - 32'(w_len));
    assign w_g    = r_goto_oor ? 7'd0 : w_goto_rd;
    assign o_hold = (r_state == BS_CLEAR);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_count      = r_count;
        n_top        = r_top;
        n_status     = r_status;
        n_nred       = r_nred;
        n_token      = r_token;
        n_act_oor    = r_act_oor;
        n_goto_oor   = r_goto_oor;
        n_rule       = r_rule;
        n_lhs        = r_lhs;
        n_base       = r_base;
        o_cmd_pop    = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = f_res(lrsr_pkg::EV_HALTED, 7'd0, r_top, r_count, 1'b1);
        w_act_we     = 1'b0;
        w_act_waddr  = f_act_addr(i_cmd.tstate, i_cmd.tterm);
        w_act_wdata  = {i_cmd.kind, i_cmd.target};
        w_act_re     = 1'b0;
        w_act_raddr  = f_act_addr(r_top, i_cmd.token);
        w_goto_we    = 1'b0;
        w_goto_waddr = f_goto_addr(i_cmd.tstate, i_cmd.tnt);
        w_goto_wdata = i_cmd.target;
        w_goto_re    = 1'b0;
        w_goto_raddr = f_goto_addr(w_stk_rd, r_lhs);
        w_rule_we    = 1'b0;
        w_rule_waddr = RAW'(i_cmd.rnum);
        w_rule_wdata = {i_cmd.tnt, i_cmd.rlen};
        w_rule_re    = 1'b0;
        w_rule_raddr = RAW'(w_tgt);
        w_stk_we     = 1'b0;
        w_stk_waddr  = SAW'(r_count);
        w_stk_wdata  = w_tgt;
        w_stk_re     = 1'b0;
        w_stk_raddr  = SAW'(w_base - CW'(1));

        unique case (r_state)
            BS_CLEAR: begin
                // sweep both tables to empty; entry zero of the stack holds state zero
                w_act_we     = (32'(r_clr) < 32'(ADEPTH));
                w_act_waddr  = AAW'(r_clr);
                w_act_wdata  = '0;
                w_goto_we    = (32'(r_clr) < 32'(GDEPTH));
                w_goto_waddr = GAW'(r_clr);
                w_goto_wdata = '0;
                w_stk_we     = 1'b1;
                w_stk_waddr  = '0;
                w_stk_wdata  = '0;
                n_clr        = r_clr + CLW'(1);
                if (r_clr == CLW'(CLR_LEN - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        lrsr_pkg::OP_TOKEN: begin
                            if (!i_res_full) begin
                                o_cmd_pop = 1'b1;
                                if (r_status != lrsr_pkg::RUN_GO) begin
                                    o_res_valid = 1'b1;
                                end else begin
                                    w_act_re  = 1'b1;
                                    n_act_oor = f_act_oor(r_top, i_cmd.token);
                                    n_token   = i_cmd.token;
                                    n_nred    = '0;
                                    n_state   = BS_ACT;
                                end
                            end
                        end
                        lrsr_pkg::OP_ACT_WR: begin
                            o_cmd_pop = 1'b1;
                            w_act_we  = 1'b1;
                        end
                        lrsr_pkg::OP_GOTO_WR: begin
                            o_cmd_pop = 1'b1;
                            w_goto_we = 1'b1;
                        end
                        lrsr_pkg::OP_RULE_WR: begin
                            o_cmd_pop = 1'b1;
                            w_rule_we = 1'b1;
                        end
                        lrsr_pkg::OP_RESTART: begin
                            o_cmd_pop = 1'b1;
                            n_count   = CW'(1);
                            n_top     = '0;
                            n_status  = lrsr_pkg::RUN_GO;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BS_ACT: begin
                if (!i_res_full) begin
                    unique case (w_kind)
                        lrsr_pkg::K_EMPTY: begin
                            o_res_valid = 1'b1;
                            o_res       = f_res(lrsr_pkg::EV_SYNTAX, 7'd0, r_top, r_count, 1'b1);
                            n_status    = lrsr_pkg::RUN_ERR;
                            n_state     = BS_IDLE;
                        end
                        lrsr_pkg::K_ACCEPT: begin
                            o_res_valid = 1'b1;
                            o_res       = f_res(lrsr_pkg::EV_ACCEPT, 7'd0, r_top, r_count, 1'b1);
                            n_status    = lrsr_pkg::RUN_ACC;
                            n_state     = BS_IDLE;
                        end
                        lrsr_pkg::K_SHIFT: begin
                            o_res_valid = 1'b1;
                            n_state     = BS_IDLE;
                            if (32'(r_count) >= 32'(STACK_DEPTH)) begin
                                o_res    = f_res(lrsr_pkg::EV_STACK, 7'd0, r_top, r_count, 1'b1);
                                n_status = lrsr_pkg::RUN_ERR;
                            end else begin
                                w_stk_we = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_top    = w_tgt;
                                o_res    = f_res(lrsr_pkg::EV_SHIFT, 7'd0, w_tgt,
                                                 r_count + CW'(1), 1'b1);
                            end
                        end
                        lrsr_pkg::K_REDUCE: begin
                            if ((32'(r_nred) >= 32'(MAX_REDUCE))
                                    || (32'(w_tgt) >= 32'(RULES))) begin
                                o_res_valid = 1'b1;
                                o_res    = f_res(lrsr_pkg::EV_STACK, 7'd0, r_top, r_count, 1'b1);
                                n_status = lrsr_pkg::RUN_ERR;
                                n_state  = BS_IDLE;
                            end else begin
                                w_rule_re = 1'b1;
                                n_rule    = w_tgt;
                                n_state   = BS_RULE;
                            end
                        end
                        default: begin
                            n_state = BS_IDLE;
                        end
                    endcase
                end
            end
            BS_RULE: begin
                if (!i_res_full) begin
                    if ((32'(w_len) >= 32'(r_count))
                            || (32'(w_base) >= 32'(STACK_DEPTH))) begin
                        // underflow, or nothing popped onto a full stack
                        o_res_valid = 1'b1;
                        o_res    = f_res(lrsr_pkg::EV_STACK, 7'd0, r_top, r_count, 1'b1);
                        n_status = lrsr_pkg::RUN_ERR;
                        n_state  = BS_IDLE;
                    end else begin
                        w_stk_re = 1'b1;
                        n_base   = w_base;
                        n_lhs    = w_lhs;
                        n_state  = BS_STK;
                    end
                end
            end
            BS_STK: begin
                w_goto_re  = 1'b1;
                n_goto_oor = !((32'(w_stk_rd) < 32'(STATES))
                            && (32'(r_lhs) < 32'(NONTERMINALS)));
                n_state    = BS_GOTO;
            end
            BS_GOTO: begin
                if (!i_res_full) begin
                    w_stk_we    = 1'b1;
                    w_stk_waddr = SAW'(r_base);
                    w_stk_wdata = w_g;
                    n_count     = r_base + CW'(1);
                    n_top       = w_g;
                    n_nred      = r_nred + NW'(1);
                    o_res_valid = 1'b1;
                    o_res       = f_res(lrsr_pkg::EV_REDUCE, r_rule, w_g,
                                        r_base + CW'(1), 1'b0);
                    w_act_re    = 1'b1;
                    w_act_raddr = f_act_addr(w_g, r_token);
                    n_act_oor   = f_act_oor(w_g, r_token);
                    n_state     = BS_ACT;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_CLEAR;
            r_clr    <= '0;
            r_count  <= CW'(1);
            r_top    <= '0;
            r_status <= lrsr_pkg::RUN_GO;
            r_nred   <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_count  <= n_count;
            r_top    <= n_top;
            r_status <= n_status;
            r_nred   <= n_nred;
        end
    end

    always_ff @(posedge i_clk) begin
        r_token    <= n_token;
        r_act_oor  <= n_act_oor;
        r_goto_oor <= n_goto_oor;
        r_rule     <= n_rule;
        r_lhs      <= n_lhs;
        r_base     <= n_base;
    end

    lrsr_ram #(.WIDTH(9), .DEPTH(ADEPTH)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (w_act_we),
        .i_waddr (w_act_waddr),
        .i_wdata (w_act_wdata),
        .i_re    (w_act_re),
        .i_raddr (w_act_raddr),
        .o_rdata (w_act_rd)
    );

    lrsr_ram #(.WIDTH(7), .DEPTH(GDEPTH)) u_goto_ram (
        .i_clk   (i_clk),
        .i_we    (w_goto_we),
        .i_waddr (w_goto_waddr),
        .i_wdata (w_goto_wdata),
        .i_re    (w_goto_re),
        .i_raddr (w_goto_raddr),
        .o_rdata (w_goto_rd)
    );

    lrsr_ram #(.WIDTH(8), .DEPTH(RULES)) u_rule_ram (
        .i_clk   (i_clk),
        .i_we    (w_rule_we),
        .i_waddr (w_rule_waddr),
        .i_wdata (w_rule_wdata),
        .i_re    (w_rule_re),
        .i_raddr (w_rule_raddr),
        .o_rdata (w_rule_rd)
    );

    lrsr_ram #(.WIDTH(7), .DEPTH(STACK_DEPTH)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_re    (w_stk_re),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rd)
    );

endmodule

`default_nettype wire

// File: rtl/lr_shift_reduce_parse_engine_unit.sv
// Top level of the table-driven LR shift-reduce parse engine.
//
// Table-driven LR shift-reduce parse engine. Items are pushed through a
// queue-style port (push/full) and results come out of a second queue
// (empty/pop); a result sits on the o_* ports while empty is low and
// leaves on the transfer with pop high. Load items write the action
// table, the goto table or the rule table; a restart item resets the
// state stack to the single state zero and clears the halt. A token item
// gives one reduce result per reduction and then one final result
// (shift, accept, syntax error, stack/chain error or halted) with o_last
// set. After accept or any error every token gives a halted result until
// a restart. Items enter a four-deep command queue, so transfers are
// taken while the sequencer works. The sequencer handles a load or
// restart item in its idle state. A token starts with an action table
// read; each reduction then steps through a rule table read, a stack
// read of the uncovered state, a goto table read and a new action table
// read, each through a RAM with registered read data. The sequencer
// pauses while the four-deep result queue is full. After reset a
// clearing pass writes the action and goto tables to empty, one entry
// per cycle over max(STATES*TERMINALS, STATES*NONTERMINALS) entries
// (4096 with the default parameters); full stays high throughout. Rule
// entries are undefined until written, and reducing by an unwritten rule
// is not supported.
`default_nettype none

module lr_shift_reduce_parse_engine_unit #(
    parameter int STATES       = 128,
    parameter int TERMINALS    = 32,
    parameter int NONTERMINALS = 16,
    parameter int RULES        = 128,
    parameter int STACK_DEPTH  = 64,
    parameter int MAX_REDUCE   = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item queue
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_mode,
    input  wire logic [4:0]  i_token,
    input  wire logic [6:0]  i_table_state,
    input  wire logic [4:0]  i_table_terminal,
    input  wire logic [3:0]  i_table_nonterminal,
    input  wire logic [1:0]  i_entry_kind,
    input  wire logic [6:0]  i_entry_target,
    input  wire logic [6:0]  i_rule_number,
    input  wire logic [3:0]  i_rule_length,
    // result queue
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_event_res,
    output logic [6:0]       o_rule,
    output logic [6:0]       o_new_state,
    output logic [6:0]       o_stack_depth,
    output logic             o_last
);

    logic                              w_hold;
    logic                              w_cmd_valid;
    lrsr_pkg::t_cmd                    w_cmd;
    logic                              w_cmd_pop;
    logic                              w_res_valid;
    lrsr_pkg::t_res                    w_res;
    logic                              w_res_full;
    logic [$bits(lrsr_pkg::t_res)-1:0] w_res_bits;
    lrsr_pkg::t_res                    w_res_head;

    // front: classify items, drop unused modes and out-of-range writes
    lrsr_front #(
        .STATES       (STATES),
        .TERMINALS    (TERMINALS),
        .NONTERMINALS (NONTERMINALS),
        .RULES        (RULES)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .o_full              (full),
        .i_mode              (i_mode),
        .i_token             (i_token),
        .i_table_state       (i_table_state),
        .i_table_terminal    (i_table_terminal),
        .i_table_nonterminal (i_table_nonterminal),
        .i_entry_kind        (i_entry_kind),
        .i_entry_target      (i_entry_target),
        .i_rule_number       (i_rule_number),
        .i_rule_length       (i_rule_length),
        .i_hold              (w_hold),
        .o_cmd_valid         (w_cmd_valid),
        .o_cmd               (w_cmd),
        .i_cmd_pop           (w_cmd_pop)
    );

    // back: tables, stack and parse sequencer
    lrsr_back #(
        .STATES       (STATES),
        .TERMINALS    (TERMINALS),
        .NONTERMINALS (NONTERMINALS),
        .RULES        (RULES),
        .STACK_DEPTH  (STACK_DEPTH),
        .MAX_REDUCE   (MAX_REDUCE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_hold      (w_hold),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    // result queue decouples the sequencer from the consumer
    lrsr_fifo #(
        .WIDTH ($bits(lrsr_pkg::t_res)),
        .DEPTH (lrsr_pkg::QDEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_bits),
        .o_empty (empty)
    );

    assign w_res_head    = lrsr_pkg::t_res'(w_res_bits);
    assign o_event_res   = w_res_head.event_res;
    assign o_rule        = w_res_head.rule;
    assign o_new_state   = w_res_head.new_state;
    assign o_stack_depth = w_res_head.stack_depth;
    assign o_last        = w_res_head.last;

endmodule

`default_nettype wire

// File: rtl/lrsr_chk.sv
// Port-level checker for the parse engine, bound to the top level.
`default_nettype none

`include "lr_shift_reduce_parse_engine_unit_assert.svh"

module lrsr_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [2:0]  o_event_res,
    input wire logic [6:0]  o_rule,
    input wire logic [6:0]  o_new_state,
    input wire logic [6:0]  o_stack_depth,
    input wire logic        o_last
);

    // clearing pass holds off input, and no result is waiting
    `LRSR_ASSERT_IMP(a_reset_clear, i_clk, i_rst_n, $past(!i_rst_n), full && empty, "not clearing after reset")

    // only a reduce carries a rule, and every other result ends the token
    `LRSR_ASSERT_IMP(a_final_event, i_clk, i_rst_n, !empty && (o_event_res != lrsr_pkg::EV_REDUCE), (o_rule == 7'd0) && o_last, "final result malformed")

    `LRSR_ASSERT_IMP(a_reduce_not_last, i_clk, i_rst_n, !empty && (o_event_res == lrsr_pkg::EV_REDUCE), !o_last, "reduce marked last")

    // a waiting result holds until it is taken
    `LRSR_ASSERT_NXT(a_result_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_event_res) && $stable(o_rule) && $stable(o_new_state) && $stable(o_stack_depth) && $stable(o_last), "waiting result changed")

endmodule

bind lr_shift_reduce_parse_engine_unit lrsr_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_event_res   (o_event_res),
    .o_rule        (o_rule),
    .o_new_state   (o_new_state),
    .o_stack_depth (o_stack_depth),
    .o_last        (o_last)
);

`default_nettype wire
